/* hdl/cprc_pkg.sv */
// Shared types and constants for the card page-read reply checker.
package cprc_pkg;

  localparam int unsigned BLOCK_BYTES = 144;
  localparam int unsigned CHUNK_BYTES = 128;
  localparam int unsigned TAIL_BYTES  = 16;

  localparam logic [7:0] POS_LAST        = 8'(BLOCK_BYTES - 1);
  localparam logic [7:0] POS_DATA_START  = 8'd4;
  localparam logic [7:0] POS_CHUNK_SUM   = 8'(4 + CHUNK_BYTES);
  localparam logic [7:0] POS_TAIL_END    = 8'(4 + TAIL_BYTES);
  localparam logic [7:0] POS_SETPAGE_ACK = 8'd8;
  localparam logic [7:0] POS_END_ACK     = 8'd3;

  localparam logic [7:0]  ACK_BYTE    = 8'h5a;
  localparam logic [15:0] STATUS_MASK = 16'hf000;
  localparam logic [15:0] STATUS_GOOD = 16'h1000;

  localparam logic [1:0] CFG_CHUNKS = 2'd0;
  localparam logic [1:0] CFG_TAIL   = 2'd1;

  localparam logic [1:0] KIND_PAGE   = 2'd0;
  localparam logic [1:0] KIND_TAIL   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_GOOD        = 3'd0;
  localparam logic [2:0] ST_XFER_FAIL   = 3'd1;
  localparam logic [2:0] ST_SETPAGE_ACK = 3'd2;
  localparam logic [2:0] ST_CHUNK_SUM   = 3'd3;
  localparam logic [2:0] ST_END_ACK     = 3'd4;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [15:0] transfer_status;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] item_kind;
    logic [2:0] read_status;
  } out_item_t;

  typedef struct packed {
    logic [3:0] chunks_per_page;
    logic       tail_present;
  } cfg_t;

endpackage

/* hdl/cprc_track.sv */
// Batch position tracking, ack and checksum checks, result decode.
module cprc_track #(
  parameter int unsigned MAX_FRAMES = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  cprc_pkg::in_item_t item_i,
  input  cprc_pkg::cfg_t    cfg_i,
  output logic              res_valid_o,
  output cprc_pkg::out_item_t res_o
);
  import cprc_pkg::*;

  localparam logic [4:0] MaxFramesW = 5'(MAX_FRAMES);
  localparam logic [3:0] EndCut     = 4'(MAX_FRAMES - 1);

  logic [7:0] pos_q, pos_d;
  logic [3:0] blk_q, blk_d;
  logic [7:0] par_q, par_d;
  logic       sp_q, sp_d, sums_q, sums_d, end_q, end_d;

  logic [4:0] frames;
  logic       too_long;
  logic [3:0] last_blk;
  logic       is_end, is_chunk, is_tail, final_byte, xfer_bad;
  logic [7:0] b;

  always_comb begin
    b          = item_i.rx_byte;
    frames     = 5'd2 + {1'b0, cfg_i.chunks_per_page} + {4'd0, cfg_i.tail_present};
    too_long   = frames >= MaxFramesW;
    last_blk   = too_long ? EndCut : (frames[3:0] - 4'd1);
    is_end     = (blk_q != 4'd0) && (blk_q == last_blk);
    is_chunk   = (blk_q != 4'd0) && !is_end && (blk_q <= cfg_i.chunks_per_page);
    is_tail    = (blk_q != 4'd0) && !is_end && !is_chunk && cfg_i.tail_present &&
                 ({1'b0, blk_q} == 5'd1 + {1'b0, cfg_i.chunks_per_page});
    final_byte = (blk_q == last_blk) && (pos_q == POS_LAST);
    xfer_bad   = too_long || ((item_i.transfer_status & STATUS_MASK) != STATUS_GOOD);

    pos_d  = pos_q;
    blk_d  = blk_q;
    par_d  = par_q;
    sp_d   = sp_q;
    sums_d = sums_q;
    end_d  = end_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (blk_q == 4'd0) begin
      if (pos_q == POS_SETPAGE_ACK && b == ACK_BYTE) sp_d = 1'b1;
    end else if (is_end) begin
      if (pos_q == POS_END_ACK && b == ACK_BYTE) end_d = 1'b1;
    end else if (is_chunk) begin
      if (pos_q >= POS_DATA_START && pos_q < POS_CHUNK_SUM) begin
        par_d = (pos_q == POS_DATA_START) ? b : (par_q ^ b);
        res_valid_o = 1'b1;
        res_o.out_byte  = b;
        res_o.item_kind = KIND_PAGE;
      end else if (pos_q == POS_CHUNK_SUM) begin
        if (par_q != b) sums_d = 1'b0;
      end
    end else if (is_tail) begin
      if (pos_q >= POS_DATA_START && pos_q < POS_TAIL_END) begin
        res_valid_o = 1'b1;
        res_o.out_byte  = b;
        res_o.item_kind = KIND_TAIL;
      end
    end

    if (final_byte) begin
      res_valid_o = 1'b1;
      res_o.out_byte  = '0;
      res_o.item_kind = KIND_STATUS;
      if (xfer_bad)     res_o.read_status = ST_XFER_FAIL;
      else if (!sp_q)   res_o.read_status = ST_SETPAGE_ACK;
      else if (!end_q)  res_o.read_status = ST_END_ACK;
      else if (!sums_q) res_o.read_status = ST_CHUNK_SUM;
      else              res_o.read_status = ST_GOOD;
      pos_d  = '0;
      blk_d  = '0;
      par_d  = '0;
      sp_d   = 1'b0;
      sums_d = 1'b1;
      end_d  = 1'b0;
    end else if (pos_q == POS_LAST) begin
      pos_d = '0;
      blk_d = blk_q + 4'd1;
    end else begin
      pos_d = pos_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      blk_q  <= '0;
      par_q  <= '0;
      sp_q   <= 1'b0;
      sums_q <= 1'b1;
      end_q  <= 1'b0;
    end else if (fire_i) begin
      pos_q  <= pos_d;
      blk_q  <= blk_d;
      par_q  <= par_d;
      sp_q   <= sp_d;
      sums_q <= sums_d;
      end_q  <= end_d;
    end
  end

endmodule

/* hdl/card_page_read_reply_checker.sv */
// Card page-read reply checker: top level with input, config and result registers.
// Takes one reply byte per cycle when unstalled and passes page and tail bytes on
// unverified; the batch's last byte yields one status item (0 good, 1 transfer
// failed or batch too long, 2 set-page ack missing, 3 chunk checksum mismatch,
// 4 end ack missing). An input register feeds one pass of position/checksum
// logic into the result register. Stall on the result side backs up through both
// registers; with no stall the rate is one byte per cycle.
// Configuration takes effect at once and must be written while the block is idle.
module card_page_read_reply_checker #(
  parameter int unsigned MAX_FRAMES = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [3:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cprc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cprc_pkg::out_item_t out_item_o
);
  import cprc_pkg::*;

  cfg_t      cfg_q;
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      adv2, fire;
  logic      res_valid;
  out_item_t res;

  assign adv2       = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && adv2;
  assign in_stall_o = s1_valid_q && !adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunks_per_page <= 4'd4;
      cfg_q.tail_present    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHUNKS: cfg_q.chunks_per_page <= cfg_wdata_i;
        CFG_TAIL:   cfg_q.tail_present    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) s1_valid_q <= in_valid_i;
      if (adv2) out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) s1_item_q <= in_item_i;
    if (fire && res_valid) out_item_q <= res;
  end

  cprc_track #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (s1_item_q),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* hdl/cprc_checker.sv */
// Port-level assertions for the reply checker, bound to the top level.
module cprc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cprc_pkg::out_item_t out_item_o
);
  import cprc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.item_kind != KIND_STATUS |->
      out_item_o.read_status == ST_GOOD)
    else $error("data item carries a status code");

  a_status_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.item_kind == KIND_STATUS |-> out_item_o.out_byte == 8'd0)
    else $error("status item carries a data byte");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.item_kind == KIND_PAGE ||
      out_item_o.item_kind == KIND_TAIL || out_item_o.item_kind == KIND_STATUS)
    else $error("bad item kind");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind card_page_read_reply_checker cprc_checker u_cprc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

/* test/tb_card_page_read_reply_checker.sv */
// Testbench for the card page-read reply checker: random reply batches checked against a predictor.
module tb_card_page_read_reply_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import cprc_pkg::*;

  localparam int unsigned MAX_FRAMES     = 11;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned ITEMS_TOTAL    = 700;

  typedef enum {
    PLAN_CLEAN, PLAN_XFER, PLAN_SETPAGE, PLAN_ENDACK, PLAN_SUM, PLAN_NOISE
  } batch_plan_e;

  class reply_scoreboard;
    logic [3:0] chunks;
    logic       tail;
    logic [7:0] pos;
    logic [3:0] blk;
    logic [7:0] parity;
    bit         setpage_ok;
    bit         sums_ok;
    bit         endack_ok;
    out_item_t  expected_q[$];
    int unsigned mismatches;
    int unsigned batches_done;

    function new();
      chunks = 4'd4;
      tail = 1'b1;
      mismatches = 0;
      batches_done = 0;
      clear_batch();
    endfunction

    function void clear_batch();
      pos = '0;
      blk = '0;
      parity = '0;
      setpage_ok = 1'b0;
      sums_ok = 1'b1;
      endack_ok = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] val);
      if (idx == CFG_CHUNKS) begin
        chunks = val;
      end else if (idx == CFG_TAIL) begin
        tail = val[0];
      end
    endfunction

    function int unsigned frame_count();
      return 2 + chunks + tail;
    endfunction

    function int unsigned last_block();
      return (frame_count() >= MAX_FRAMES) ? MAX_FRAMES - 1 : frame_count() - 1;
    endfunction

    function void note_input(in_item_t it);
      logic [7:0]  b;
      logic [2:0]  st;
      bit          too_long;
      int unsigned last;
      b = it.rx_byte;
      too_long = frame_count() >= MAX_FRAMES;
      last = last_block();
      if (blk == 0) begin
        if (pos == POS_SETPAGE_ACK && b == ACK_BYTE) setpage_ok = 1'b1;
      end else if (blk == last) begin
        if (pos == POS_END_ACK && b == ACK_BYTE) endack_ok = 1'b1;
      end else if (blk <= chunks) begin
        if (pos >= POS_DATA_START && pos < POS_CHUNK_SUM) begin
          parity = (pos == POS_DATA_START) ? b : (parity ^ b);
          expected_q.push_back('{out_byte: b, item_kind: KIND_PAGE, read_status: ST_GOOD});
        end else if (pos == POS_CHUNK_SUM && parity != b) begin
          sums_ok = 1'b0;
        end
      end else if (tail && blk == chunks + 1) begin
        if (pos >= POS_DATA_START && pos < POS_TAIL_END) begin
          expected_q.push_back('{out_byte: b, item_kind: KIND_TAIL, read_status: ST_GOOD});
        end
      end
      if (blk == last && pos == POS_LAST) begin
        if (too_long || (it.transfer_status & STATUS_MASK) != STATUS_GOOD) st = ST_XFER_FAIL;
        else if (!setpage_ok) st = ST_SETPAGE_ACK;
        else if (!endack_ok) st = ST_END_ACK;
        else if (!sums_ok) st = ST_CHUNK_SUM;
        else st = ST_GOOD;
        expected_q.push_back('{out_byte: 8'h00, item_kind: KIND_STATUS, read_status: st});
        clear_batch();
        batches_done++;
        return;
      end
      if (pos == POS_LAST) begin
        pos = '0;
        blk = blk + 4'd1;
      end else begin
        pos = pos + 8'd1;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected item: out_byte %0d item_kind %0d read_status %0d",
               got.out_byte, got.item_kind, got.read_status);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.item_kind !== want.item_kind) begin
        $error("item_kind: expected %0d, got %0d", want.item_kind, got.item_kind);
        mismatches++;
      end
      if (got.read_status !== want.read_status) begin
        $error("read_status: expected %0d, got %0d", want.read_status, got.read_status);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [3:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;

  reply_scoreboard sb = new();
  batch_plan_e     fault_plan = PLAN_CLEAN;
  bit              allow_faults = 1'b0;
  int unsigned     in_calm = 0;
  int unsigned     out_calm = 0;
  int unsigned     items_sent = 0;

  card_page_read_reply_checker #(.MAX_FRAMES(MAX_FRAMES)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned idle_len(inout int unsigned calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) calm_left = $urandom_range(20, 200);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly well-formed reply content; the batch plan decides which fault goes in.
  function automatic in_item_t next_reply_byte();
    in_item_t    it;
    logic [3:0]  nib;
    int unsigned r;
    int unsigned last;
    if (sb.pos == 0 && sb.blk == 0) begin
      r = $urandom_range(0, 99);
      if (!allow_faults || r < 40) fault_plan = PLAN_CLEAN;
      else if (r < 52) fault_plan = PLAN_XFER;
      else if (r < 64) fault_plan = PLAN_SETPAGE;
      else if (r < 76) fault_plan = PLAN_ENDACK;
      else if (r < 88) fault_plan = PLAN_SUM;
      else fault_plan = PLAN_NOISE;
    end
    it.rx_byte = 8'($urandom);
    it.transfer_status = 16'($urandom);
    if (fault_plan == PLAN_NOISE) return it;
    last = sb.last_block();
    if (sb.blk == 0) begin
      if (sb.pos == POS_SETPAGE_ACK && fault_plan != PLAN_SETPAGE) it.rx_byte = ACK_BYTE;
    end else if (sb.blk == last) begin
      if (sb.pos == POS_END_ACK && fault_plan != PLAN_ENDACK) it.rx_byte = ACK_BYTE;
      if (sb.pos == POS_LAST) begin
        if (fault_plan == PLAN_XFER) begin
          nib = 4'($urandom_range(0, 14));
          if (nib >= STATUS_GOOD[15:12]) nib = nib + 4'd1;
          it.transfer_status = {nib, 12'($urandom)};
        end else begin
          it.transfer_status = STATUS_GOOD | (16'($urandom) & ~STATUS_MASK);
        end
      end
    end else if (sb.blk <= sb.chunks && sb.pos == POS_CHUNK_SUM) begin
      it.rx_byte = sb.parity;
      if (fault_plan == PLAN_SUM && $urandom_range(0, 1) == 1)
        it.rx_byte = sb.parity ^ 8'($urandom_range(1, 255));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned g;
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    items_sent++;
    g = idle_len(in_calm);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Sends bytes until the current batch closes, or until max_bytes when whole is clear.
  task automatic run_bytes(input int unsigned max_bytes, input bit whole);
    int unsigned start_done;
    int unsigned n;
    start_done = sb.batches_done;
    n = 0;
    while (sb.batches_done == start_done && (whole || n < max_bytes)) begin
      send_item(next_reply_byte());
      n++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic program_regs(input logic [3:0] chunks, input logic tail_on);
    logic [3:0] tail_word;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tail_word = {3'($urandom), tail_on};
    cfg_we <= 1'b1;
    cfg_idx <= CFG_CHUNKS;
    cfg_wdata <= chunks;
    @(posedge clk);
    sb.write_reg(CFG_CHUNKS, chunks);
    cfg_idx <= CFG_TAIL;
    cfg_wdata <= tail_word;
    @(posedge clk);
    sb.write_reg(CFG_TAIL, tail_word);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned stall_left;
    int unsigned g;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        g = idle_len(out_calm);
        if (g > 0) stall_left = g - 1;
        out_stall <= (g > 0);
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_item_t    it;
    int unsigned r;
    int unsigned budget;
    logic [3:0]  chunks;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_CHUNKS;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_item <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes at the head of the first batch, then the rest of it clean
    program_regs(4'd0, 1'b0);
    for (int k = 0; k < 24; k++) begin
      it = next_reply_byte();
      if (sb.pos != POS_SETPAGE_ACK) it.rx_byte = k[0] ? 8'hff : 8'h00;
      it.transfer_status = k[0] ? 16'hffff : 16'h0000;
      send_item(it);
    end
    run_bytes(0, 1'b1);

    allow_faults = 1'b1;
    while (items_sent < ITEMS_TOTAL) begin
      r = $urandom_range(0, 99);
      if (r < 70) chunks = 4'($urandom_range(0, 2));
      else if (r < 85) chunks = 4'($urandom_range(3, 8));
      else chunks = 4'($urandom_range(9, 15));
      program_regs(chunks, 1'($urandom));
      budget = ITEMS_TOTAL - items_sent;
      if ($urandom_range(0, 4) == 0) run_bytes($urandom_range(1, budget), 1'b0);
      else run_bytes(budget, 1'b0);
    end

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected items never arrived", sb.expected_q.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
